/* rtl/core/simlu_pkg.sv */
// simlu_pkg: shared types and codes for the sorted inverse map lookup.
// No dependencies.
`timescale 1ns / 1ps
package simlu_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] key_value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [9:0] position;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch accepted transaction
    logic load_store;  // write loaded value at count
    logic clear_table; // drop old table before load
    logic sort_init;   // i = 1
    logic sort_rd_key; // read entry i as key
    logic sort_rd_j;   // read entry j-1
    logic sort_shift;  // entry[j] <= entry[j-1], j--
    logic sort_place;  // entry[j] <= key, i++
    logic set_ready;
    logic srch_init;
    logic srch_rd;     // read entry mid
    logic srch_step;   // update range from registered read
    logic res_miss;    // result not found
    logic res_hit;     // result found at mid
  } simlu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_lookup;
    logic is_last;
    logic table_ready;
    logic sort_done;   // i >= count
    logic j_zero;
    logic key_less;    // sort key < entry j-1, ties by index
    logic srch_empty;  // hi <= lo
    logic srch_eq;
  } simlu_sts_t;

endpackage

/* rtl/core/sorted_inverse_map_lookup.sv */
// sorted_inverse_map_lookup: top level, loads pairs, sorts, answers lookups.
// Depends on simlu_pkg, simlu_ctrl, simlu_datapath.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | in_item  (op, key_value, last)
//   out     | out_valid / out_ready| out_item (found, position)
//
// A load runs decode then store, with a second store pass when it first
// drops a finished table. A last-marked load then insertion-sorts the pair
// memory: a key read per element, a read and a compare per compare, O(n^2)
// in the worst case. A lookup does a read and a compare per probe and one
// more read step on a miss, at most 11 probes at 1024 entries. One
// transaction is worked at a time. Reset empties the table; the pair
// memory is not cleared. A stalled result holds in_ready low until out_ready takes it.
`timescale 1ns / 1ps
module sorted_inverse_map_lookup
  import simlu_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);
  simlu_cmd_t cmd;
  simlu_sts_t sts;

  simlu_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  simlu_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk, .rst, .in_item, .cmd, .sts, .result(out_item)
  );
endmodule

/* rtl/core/simlu_datapath.sv */
// simlu_datapath: pair memory, insertion sort and halving search datapath.
// Depends on simlu_pkg.
`timescale 1ns / 1ps
module simlu_datapath
  import simlu_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_item,
  input  simlu_cmd_t cmd,
  output simlu_sts_t sts,
  output out_item_t  result
);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_ENTRIES);

  logic [31:0] mem_val [MAX_ENTRIES];
  logic [AW-1:0] mem_idx [MAX_ENTRIES];

  in_item_t    item;
  logic [CW-1:0] count, i_cnt, j_cnt, lo, hi, mid;
  logic [31:0] key_v;   // sign-flipped sort key or search key
  logic [AW-1:0] key_x;
  logic [31:0] rd_val;
  logic [AW-1:0] rd_idx;
  logic        ready_flag;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_val;
  logic [AW-1:0] wr_idx;
  logic [31:0] item_flip;

  assign item_flip = {~item.key_value[31], item.key_value[30:0]};

  always_comb begin
    rd_addr = mid[AW-1:0];
    if (cmd.sort_rd_key) rd_addr = i_cnt[AW-1:0];
    else if (cmd.sort_rd_j) rd_addr = AW'(j_cnt - CW'(1));
    wr_en = 1'b0; wr_addr = AW'(count); wr_val = item_flip; wr_idx = AW'(count);
    if (cmd.load_store) begin
      wr_en = (count < CAP);
    end else if (cmd.sort_shift) begin
      wr_en = 1'b1; wr_addr = AW'(j_cnt); wr_val = rd_val; wr_idx = rd_idx;
    end else if (cmd.sort_place) begin
      wr_en = 1'b1; wr_addr = AW'(j_cnt); wr_val = key_v; wr_idx = key_x;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_val[wr_addr] <= wr_val;
      mem_idx[wr_addr] <= wr_idx;
    end
    rd_val <= mem_val[rd_addr];
    rd_idx <= mem_idx[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ready_flag <= 1'b0;
    end else begin
      if (cmd.clear_table) begin
        count <= '0;
        ready_flag <= 1'b0;
      end else if (cmd.load_store && count < CAP) begin
        count <= count + CW'(1);
      end
      if (cmd.set_ready) ready_flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_item;
    if (cmd.sort_init) i_cnt <= CW'(1);
    if (cmd.sort_rd_key) j_cnt <= i_cnt;
    if (cmd.sort_shift) j_cnt <= j_cnt - CW'(1);
    if (cmd.sort_place) i_cnt <= i_cnt + CW'(1);
    if (cmd.srch_init) begin
      lo <= '0; hi <= count; key_v <= item_flip;
      mid <= count >> 1;
    end
    if (cmd.srch_step) begin
      if (rd_val < key_v) begin
        lo <= mid + CW'(1);
        mid <= (mid + CW'(1)) + ((hi - mid - CW'(1)) >> 1);
      end else begin
        hi <= mid;
        mid <= lo + ((mid - lo) >> 1);
      end
    end
    // key capture: in the cycle after sort_rd_key issues the read
    if (cmd.sort_rd_j && j_cnt == i_cnt) begin
      key_v <= rd_val; key_x <= rd_idx;
    end
    if (cmd.res_miss) result <= '0;
    if (cmd.res_hit) begin
      result.found <= 1'b1;
      result.position <= 10'(rd_idx);
    end
  end

  assign sts.is_lookup   = (item.op == OP_LOOKUP);
  assign sts.is_last     = item.last;
  assign sts.table_ready = ready_flag;
  assign sts.sort_done   = (i_cnt >= count);
  assign sts.j_zero      = (j_cnt == '0);
  assign sts.key_less    = (key_v < rd_val) || (key_v == rd_val && key_x < rd_idx);
  assign sts.srch_empty  = (hi <= lo);
  assign sts.srch_eq     = (rd_val == key_v);
endmodule

/* rtl/core/simlu_ctrl.sv */
// simlu_ctrl: sequencer for load, insertion sort and lookup.
// Depends on simlu_pkg.
`timescale 1ns / 1ps
module simlu_ctrl
  import simlu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  simlu_sts_t sts,
  output simlu_cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_LOAD, S_SORT_KEY, S_SORT_RDJ, S_SORT_CMP,
    S_SRCH_RD, S_SRCH_CMP, S_OUT
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    cmd.capture = (state == S_IDLE) && in_valid;
    case (state)
      S_LOAD: begin
        cmd.clear_table = sts.table_ready;
      end
      S_SORT_KEY: cmd.sort_rd_key = !sts.sort_done;
      S_SORT_RDJ: cmd.sort_rd_j = !sts.j_zero;
      S_SORT_CMP: begin
        if (sts.key_less) cmd.sort_shift = 1'b1;
        else cmd.sort_place = 1'b1;
      end
      S_SRCH_RD: begin
        cmd.srch_rd  = 1'b1;
        // range ran out: key absent
        cmd.res_miss = sts.srch_empty;
      end
      S_SRCH_CMP: begin
        if (sts.srch_eq) cmd.res_hit = 1'b1;
        else cmd.srch_step = 1'b1;
      end
      default: ;
    endcase
    if (state == S_DECODE) begin
      if (sts.is_lookup) begin
        cmd.srch_init = sts.table_ready;
        cmd.res_miss  = !sts.table_ready;
      end
    end
    if (state == S_LOAD && !sts.table_ready) begin
      cmd.load_store = 1'b1;
      cmd.sort_init  = sts.is_last;
    end
    if (state == S_SORT_KEY && sts.sort_done) cmd.set_ready = 1'b1;
    if (state == S_SORT_RDJ && sts.j_zero) cmd.sort_place = 1'b1;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:   if (in_valid) state <= S_DECODE;
        S_DECODE: begin
          if (!sts.is_lookup) state <= S_LOAD;
          else if (sts.table_ready) state <= S_SRCH_RD;
          else state <= S_OUT;
        end
        // when a stale table is cleared, come back here to store
        S_LOAD: begin
          if (sts.table_ready) state <= S_LOAD;
          else if (sts.is_last) state <= S_SORT_KEY;
          else state <= S_IDLE;
        end
        S_SORT_KEY: state <= sts.sort_done ? S_IDLE : S_SORT_RDJ;
        S_SORT_RDJ: state <= sts.j_zero ? S_SORT_KEY : S_SORT_CMP;
        S_SORT_CMP: state <= sts.key_less ? S_SORT_RDJ : S_SORT_KEY;
        S_SRCH_RD:  state <= sts.srch_empty ? S_OUT : S_SRCH_CMP;
        S_SRCH_CMP: state <= sts.srch_eq ? S_OUT : S_SRCH_RD;
        S_OUT:      if (out_ready) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end
endmodule
